FILE: design/aept_pkg.sv
// Shared types and constants for the aging entity position table.
package aept_pkg;

    // Table geometry
    localparam int TABLE_ENTRIES = 64;
    localparam int AGE_BITS      = 16;
    localparam int INDEX_W       = $clog2(TABLE_ENTRIES);
    localparam int COUNT_W       = $clog2(TABLE_ENTRIES + 1);

    // Field widths fixed by the interface
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;
    localparam int KEY_W     = 32;
    localparam int POSE_W    = 192;
    localparam int FIELD_W   = 7;

    // Packet filter
    localparam logic [15:0] MIN_LENGTH = 16'd94;
    localparam logic [7:0]  POSE_TYPE  = 8'h96;

    // Configuration defaults
    localparam logic [CFG_W-1:0] PRUNE_INTERVAL_RST = 16'd5000;
    localparam logic [CFG_W-1:0] PRUNE_AGE_RST      = 16'd500;

    localparam logic [AGE_BITS-1:0] AGE_MAX = '1;
    localparam logic [AGE_BITS-1:0] AGE_ONE = AGE_BITS'(1);
    localparam logic [15:0]         PKT_CNT_MAX = 16'hFFFF;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PRUNE_INTERVAL = 1'b0,
        REG_PRUNE_AGE      = 1'b1
    } cfg_reg_t;

    // Input transaction
    typedef struct packed {
        logic [15:0] packet_length;
        logic [7:0]  type_byte;
        logic [31:0] entity_key;
        logic [31:0] pos_x_bits;
        logic [31:0] pos_y_bits;
        logic [31:0] pos_z_bits;
        logic [31:0] pitch_bits;
        logic [31:0] yaw_bits;
        logic [31:0] roll_bits;
    } in_item_t;

    // Result transaction
    typedef struct packed {
        logic               accepted;
        logic               inserted_new;
        logic               dropped_full;
        logic               sweep_done;
        logic [FIELD_W-1:0] removed_count;
        logic [FIELD_W-1:0] occupancy;
    } out_item_t;

    // One table word
    typedef struct packed {
        logic [KEY_W-1:0]    key;
        logic [AGE_BITS-1:0] age;
        logic [POSE_W-1:0]   pose;
    } entry_t;

    // Engine status handed to the output stage
    typedef struct packed {
        logic               valid;
        logic               accepted;
        logic               inserted_new;
        logic               dropped_full;
        logic               sweep_done;
        logic [COUNT_W-1:0] removed;
        logic [COUNT_W-1:0] occupancy;
    } eng_result_t;

    // Engine sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT,
        ST_REPORT
    } eng_state_t;

endpackage

FILE: design/aept_ram.sv
// Generic simple dual-port RAM with registered read data.
module aept_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/aept_engine.sv
// Table engine: lookup, aging and prune sweep in one pass over the entry RAM.
module aept_engine
    import aept_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic             pass,
    input  in_item_t         item,
    input  logic [CFG_W-1:0] prune_interval,
    input  logic [CFG_W-1:0] prune_age,
    input  logic             out_free,
    output logic             ready,
    output eng_result_t      result
);

    localparam logic [INDEX_W-1:0] LAST_IDX = INDEX_W'(TABLE_ENTRIES - 1);

    eng_state_t               state_reg, state_next;
    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;
    logic [INDEX_W-1:0]       idx_reg, idx_next;
    logic                     hit_found_reg, hit_found_next;
    logic                     free_found_reg, free_found_next;
    logic [INDEX_W-1:0]       free_idx_reg, free_idx_next;
    logic [KEY_W-1:0]         key_reg, key_next;
    logic [POSE_W-1:0]        pose_reg, pose_next;
    logic                     pass_reg, pass_next;
    logic                     sweep_reg, sweep_next;
    logic                     inserted_reg, inserted_next;
    logic                     dropped_reg, dropped_next;
    logic [15:0]              pkt_cnt_reg, pkt_cnt_next;
    logic [COUNT_W-1:0]       occ_reg, occ_next;
    logic [COUNT_W-1:0]       removed_reg, removed_next;

    // RAM port signals
    logic               ram_we;
    logic [INDEX_W-1:0] ram_waddr;
    entry_t             ram_wdata;
    logic [INDEX_W-1:0] ram_raddr;
    entry_t             ram_rdata;

    // Scan datapath
    logic               ent_valid;
    logic               is_hit;
    logic [AGE_BITS-1:0] aged;
    logic               rm_scan;
    logic               rm_new;
    logic               do_insert;
    logic [15:0]        cnt_inc;

    aept_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (TABLE_ENTRIES)
    ) u_entry_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Per-entry update for the word returned by the RAM
    always_comb begin
        ent_valid = valid_reg[idx_reg];
        is_hit    = ent_valid && !hit_found_reg && (ram_rdata.key == key_reg);
        if (is_hit) begin
            aged = AGE_ONE;
        end else if (ram_rdata.age == AGE_MAX) begin
            aged = ram_rdata.age;
        end else begin
            aged = ram_rdata.age + AGE_ONE;
        end
        rm_scan   = ent_valid && sweep_reg && (32'(aged) >= 32'(prune_age));
        rm_new    = sweep_reg && (32'(AGE_ONE) >= 32'(prune_age));
        do_insert = !hit_found_reg && free_found_reg;
        cnt_inc   = (pkt_cnt_reg == PKT_CNT_MAX) ? pkt_cnt_reg : pkt_cnt_reg + 16'd1;
    end

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        idx_next        = idx_reg;
        hit_found_next  = hit_found_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        key_next        = key_reg;
        pose_next       = pose_reg;
        pass_next       = pass_reg;
        sweep_next      = sweep_reg;
        inserted_next   = inserted_reg;
        dropped_next    = dropped_reg;
        pkt_cnt_next    = pkt_cnt_reg;
        occ_next        = occ_reg;
        removed_next    = removed_reg;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg;
        ram_wdata       = ram_rdata;
        ram_raddr       = idx_reg + INDEX_W'(1);

        case (state_reg)
            ST_IDLE: begin
                ram_raddr = '0;
                if (start) begin
                    key_next        = item.entity_key;
                    pose_next       = {item.pos_x_bits, item.pos_y_bits, item.pos_z_bits,
                                       item.pitch_bits, item.yaw_bits, item.roll_bits};
                    pass_next       = pass;
                    sweep_next      = pass && (cnt_inc >= prune_interval);
                    inserted_next   = 1'b0;
                    dropped_next    = 1'b0;
                    removed_next    = '0;
                    hit_found_next  = 1'b0;
                    free_found_next = 1'b0;
                    idx_next        = '0;
                    if (pass) begin
                        pkt_cnt_next = (cnt_inc >= prune_interval) ? 16'd0 : cnt_inc;
                        state_next   = ST_SCAN;
                    end else begin
                        state_next   = ST_REPORT;
                    end
                end
            end

            ST_SCAN: begin
                // age, refresh on hit, prune; write the entry back
                ram_we    = ent_valid;
                ram_wdata = is_hit ? entry_t'{key: key_reg, age: aged, pose: pose_reg}
                                   : entry_t'{key: ram_rdata.key, age: aged,
                                              pose: ram_rdata.pose};
                if (is_hit) begin
                    hit_found_next = 1'b1;
                end
                if (!ent_valid && !free_found_reg) begin
                    free_found_next = 1'b1;
                    free_idx_next   = idx_reg;
                end
                if (rm_scan) begin
                    valid_next[idx_reg] = 1'b0;
                    removed_next        = removed_reg + COUNT_W'(1);
                end
                if (idx_reg == LAST_IDX) begin
                    state_next = ST_COMMIT;
                end else begin
                    idx_next = idx_reg + INDEX_W'(1);
                end
            end

            ST_COMMIT: begin
                // new key goes to the lowest entry that was free before the pass
                ram_waddr = free_idx_reg;
                ram_wdata = entry_t'{key: key_reg, age: AGE_ONE, pose: pose_reg};
                ram_we    = do_insert;
                if (do_insert) begin
                    inserted_next = 1'b1;
                    if (rm_new) begin
                        removed_next = removed_reg + COUNT_W'(1);
                        occ_next     = occ_reg - removed_reg;
                    end else begin
                        valid_next[free_idx_reg] = 1'b1;
                        occ_next = occ_reg + COUNT_W'(1) - removed_reg;
                    end
                end else begin
                    dropped_next = !hit_found_reg;
                    occ_next     = occ_reg - removed_reg;
                end
                state_next = ST_REPORT;
            end

            ST_REPORT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            valid_reg   <= '0;
            pkt_cnt_reg <= '0;
            occ_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            valid_reg   <= valid_next;
            pkt_cnt_reg <= pkt_cnt_next;
            occ_reg     <= occ_next;
        end
    end

    // Per-transaction working registers
    always_ff @(posedge aclk) begin
        idx_reg        <= idx_next;
        hit_found_reg  <= hit_found_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        key_reg        <= key_next;
        pose_reg       <= pose_next;
        pass_reg       <= pass_next;
        sweep_reg      <= sweep_next;
        inserted_reg   <= inserted_next;
        dropped_reg    <= dropped_next;
        removed_reg    <= removed_next;
    end

    assign ready = (state_reg == ST_IDLE);

    always_comb begin
        result.valid        = (state_reg == ST_REPORT);
        result.accepted     = pass_reg;
        result.inserted_new = inserted_reg;
        result.dropped_full = dropped_reg;
        result.sweep_done   = sweep_reg;
        result.removed      = removed_reg;
        result.occupancy    = occ_reg;
    end

endmodule

FILE: design/aging_entity_position_table.sv
// Top level: configuration registers, packet filter and result register.
//
// Aging entity position table. One input transaction on s_valid/s_ready is a
// parsed packet; a packet passes when its length is at least 94 and its type
// byte is 0x96. A passing packet refreshes or inserts its key (64 entries),
// ages every valid entry by one and, every prune_interval passing packets,
// removes entries whose age has reached prune_age. Each packet gives exactly
// one result transaction on m_valid/m_ready.
// A passing packet makes one pass over the entry RAM (one read per cycle),
// then a commit and a report state, before its result enters the output
// register; a rejected packet goes straight to the report state. s_ready is
// high only while the engine is idle, so a new packet is taken the cycle
// after the previous result has moved into the output register. A stalled
// m_ready holds the result in the output register; the next packet is still
// processed, then waits until the register frees.
// Reset (aresetn, synchronous, low) empties the table, clears the packet
// counter and loads prune_interval = 5000 and prune_age = 500. Registers are
// written through cfg_we/cfg_index/cfg_wdata; the user must write them only
// while no packet is in flight, as the block itself does not enforce it.
module aging_entity_position_table
    import aept_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    logic [CFG_W-1:0] prune_interval_reg;
    logic [CFG_W-1:0] prune_age_reg;
    logic             m_valid_reg, m_valid_next;
    out_item_t        m_data_reg, m_data_next;

    logic        eng_ready;
    eng_result_t eng_res;
    logic        out_free;
    logic        start;
    logic        pass;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prune_interval_reg <= PRUNE_INTERVAL_RST;
            prune_age_reg      <= PRUNE_AGE_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_PRUNE_INTERVAL: prune_interval_reg <= cfg_wdata;
                REG_PRUNE_AGE:      prune_age_reg      <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Packet filter
    assign pass    = (s_data.packet_length >= MIN_LENGTH) && (s_data.type_byte == POSE_TYPE);
    assign s_ready = eng_ready;
    assign start   = s_valid && eng_ready;

    assign out_free = !m_valid_reg || m_ready;

    aept_engine u_engine (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .start          (start),
        .pass           (pass),
        .item           (s_data),
        .prune_interval (prune_interval_reg),
        .prune_age      (prune_age_reg),
        .out_free       (out_free),
        .ready          (eng_ready),
        .result         (eng_res)
    );

    // Output register
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (eng_res.valid && out_free) begin
            m_valid_next              = 1'b1;
            m_data_next.accepted      = eng_res.accepted;
            m_data_next.inserted_new  = eng_res.inserted_new;
            m_data_next.dropped_full  = eng_res.dropped_full;
            m_data_next.sweep_done    = eng_res.sweep_done;
            m_data_next.removed_count = FIELD_W'(eng_res.removed);
            m_data_next.occupancy     = FIELD_W'(eng_res.occupancy);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: tb/tb_aging_entity_position_table.sv
// Self-checking testbench for the aging entity position table: shadow table, driver and monitor.
`timescale 1ns / 1ps

module tb_aging_entity_position_table;
    import aept_pkg::*;

    localparam int PHASES          = 10;
    localparam int PACKETS_PER_PHASE = 200;
    localparam int HOLD_CYCLES     = 700;
    localparam int DRAIN_CYCLES    = 100;

    // DUT connections; the inputs driven by the bench are known from time zero
    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    in_item_t             s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    out_item_t            m_data;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    // Shadow copy of the table and its registers
    logic                tbl_valid [TABLE_ENTRIES];
    logic [KEY_W-1:0]    tbl_key   [TABLE_ENTRIES];
    logic [AGE_BITS-1:0] tbl_age   [TABLE_ENTRIES];
    logic [15:0]         pkts_since_sweep;
    logic [CFG_W-1:0]    sweep_interval;
    logic [CFG_W-1:0]    sweep_age;

    in_item_t  packet_queue[$];
    out_item_t expected_outcomes[$];
    out_item_t predicted;
    out_item_t want;

    int errors      = 0;
    int n_packets   = 0;
    int n_accepted  = 0;
    int n_inserted  = 0;
    int n_dropped   = 0;
    int n_sweeps    = 0;
    int n_removed   = 0;
    int n_results   = 0;
    int n_writes    = 0;
    int n_holds     = 0;
    int gap_left    = 0;
    int burst_left  = 0;
    int hold_left   = 0;
    int rx_mode     = 0;
    int rx_mode_left = 0;

    aging_entity_position_table u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Lookup, refresh or insert, age, count and sweep for one packet
    function automatic out_item_t apply_packet(input in_item_t pkt);
        out_item_t res;
        int        hit;
        int        free_slot;
        int        removed;
        int        occ;
        int        i;
        res       = '0;
        hit       = -1;
        free_slot = -1;
        removed   = 0;
        occ       = 0;
        if (pkt.packet_length >= MIN_LENGTH && pkt.type_byte == POSE_TYPE) begin
            res.accepted = 1'b1;
            for (i = 0; i < TABLE_ENTRIES; i++) begin
                if (tbl_valid[i]) begin
                    if (hit < 0 && tbl_key[i] == pkt.entity_key) begin
                        hit = i;
                    end
                end else if (free_slot < 0) begin
                    free_slot = i;
                end
            end
            if (hit >= 0) begin
                tbl_age[hit] = '0;
            end else if (free_slot >= 0) begin
                tbl_valid[free_slot] = 1'b1;
                tbl_key[free_slot]   = pkt.entity_key;
                tbl_age[free_slot]   = '0;
                res.inserted_new     = 1'b1;
            end else begin
                res.dropped_full = 1'b1;
            end
            // ageing saturates
            for (i = 0; i < TABLE_ENTRIES; i++) begin
                if (tbl_valid[i] && tbl_age[i] != AGE_MAX) begin
                    tbl_age[i] = tbl_age[i] + 1'b1;
                end
            end
            if (pkts_since_sweep != PKT_CNT_MAX) begin
                pkts_since_sweep = pkts_since_sweep + 1'b1;
            end
            if (pkts_since_sweep >= sweep_interval) begin
                res.sweep_done = 1'b1;
                for (i = 0; i < TABLE_ENTRIES; i++) begin
                    if (tbl_valid[i] && tbl_age[i] >= sweep_age) begin
                        tbl_valid[i] = 1'b0;
                        removed++;
                    end
                end
                pkts_since_sweep = '0;
            end
            res.removed_count = FIELD_W'(removed);
        end
        for (i = 0; i < TABLE_ENTRIES; i++) begin
            if (tbl_valid[i]) begin
                occ++;
            end
        end
        res.occupancy = FIELD_W'(occ);
        return res;
    endfunction

    function automatic in_item_t make_packet(input logic [15:0] len, input logic [7:0] kind,
                                             input logic [31:0] key);
        in_item_t pkt;
        pkt.packet_length = len;
        pkt.type_byte     = kind;
        pkt.entity_key    = key;
        pkt.pos_x_bits    = $urandom;
        pkt.pos_y_bits    = $urandom;
        pkt.pos_z_bits    = $urandom;
        pkt.pitch_bits    = $urandom;
        pkt.yaw_bits      = $urandom;
        pkt.roll_bits     = $urandom;
        return pkt;
    endfunction

    // Mostly well-formed packets on a key pool, some stray keys and rejects
    function automatic in_item_t random_packet(input logic [31:0] key_base, input int pool);
        logic [31:0] key;
        int          pick;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 4) == 0) begin
            key = $urandom;
        end else begin
            key = key_base + 32'($urandom_range(0, pool - 1));
        end
        if (pick < 6) begin
            return make_packet(16'($urandom_range(0, 93)), POSE_TYPE, key);
        end else if (pick < 12) begin
            return make_packet(16'($urandom_range(94, 65535)), 8'($urandom), key);
        end else if (pick < 20) begin
            return make_packet(MIN_LENGTH, POSE_TYPE, key);
        end else if (pick < 24) begin
            return make_packet(16'hFFFF, POSE_TYPE, key);
        end
        return make_packet(16'($urandom_range(94, 65535)), POSE_TYPE, key);
    endfunction

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s expected %0d, actual %0d", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    // Register write; only called while nothing is in flight
    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_PRUNE_INTERVAL: sweep_interval = val;
            REG_PRUNE_AGE:      sweep_age = val;
            default: ;
        endcase
        n_writes++;
    endtask

    // Hold the sender until every expected result has come back
    task automatic wait_idle();
        @(posedge aclk);
        while (packet_queue.size() != 0 || s_valid || expected_outcomes.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    // Driver: bursts of transactions with random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predicted = apply_packet(s_data);
                expected_outcomes.push_back(predicted);
                n_packets++;
                n_accepted += predicted.accepted;
                n_inserted += predicted.inserted_new;
                n_dropped  += predicted.dropped_full;
                n_sweeps   += predicted.sweep_done;
                n_removed  += predicted.removed_count;
            end
            if (!s_valid || s_ready) begin
                if (gap_left != 0 || packet_queue.size() == 0) begin
                    s_valid <= 1'b0;
                    if (gap_left != 0) begin
                        gap_left--;
                    end
                end else begin
                    s_valid <= 1'b1;
                    s_data  <= packet_queue.pop_front();
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 16);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left--;
                    end
                end
            end
        end
    end

    // Monitor: compare each result transaction, then drive the stall pattern
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                n_results++;
                if (expected_outcomes.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %p", $time, m_data);
                    errors++;
                end else begin
                    want = expected_outcomes.pop_front();
                    check_field("accepted", want.accepted, m_data.accepted);
                    check_field("inserted_new", want.inserted_new, m_data.inserted_new);
                    check_field("dropped_full", want.dropped_full, m_data.dropped_full);
                    check_field("sweep_done", want.sweep_done, m_data.sweep_done);
                    check_field("removed_count", want.removed_count, m_data.removed_count);
                    check_field("occupancy", want.occupancy, m_data.occupancy);
                end
            end
            // long hold-off twice while the sender still has plenty queued
            if (hold_left == 0 && n_holds < 2 && packet_queue.size() > 20
                    && n_results >= ((n_holds == 0) ? 300 : 1100)) begin
                hold_left = HOLD_CYCLES;
                n_holds++;
            end
            if (rx_mode_left == 0) begin
                rx_mode      = $urandom_range(0, 2);
                rx_mode_left = $urandom_range(100, 400);
            end else begin
                rx_mode_left--;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                case (rx_mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= ($urandom_range(0, 3) != 0);
                    default: m_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Stimulus and end of run
    initial begin
        in_item_t    pkt;
        int          ph_interval [PHASES];
        int          ph_age      [PHASES];
        int          ph_pool     [PHASES];
        logic [31:0] key_base;
        int          ph;
        int          i;

        ph_interval = '{65535, 5, 1, 10, 64, 0, 20, 5000, 0, 0};
        ph_age      = '{65535, 20, 1, 30, 100, 3, 0, 500, 0, 0};
        ph_pool     = '{100, 100, 40, 80, 120, 70, 90, 64, 0, 0};

        for (i = 0; i < TABLE_ENTRIES; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_key[i]   = '0;
            tbl_age[i]   = '0;
        end
        pkts_since_sweep = '0;
        sweep_interval   = PRUNE_INTERVAL_RST;
        sweep_age        = PRUNE_AGE_RST;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset-value registers: filter edges, first inserts and a refresh
        packet_queue.push_back(make_packet(16'd0, POSE_TYPE, 32'd0));
        packet_queue.push_back(make_packet(16'd93, POSE_TYPE, 32'd0));
        packet_queue.push_back(make_packet(MIN_LENGTH, 8'h95, 32'd0));
        packet_queue.push_back(make_packet(16'hFFFF, 8'h97, 32'd0));
        packet_queue.push_back(make_packet(MIN_LENGTH, POSE_TYPE, 32'd0));
        pkt = make_packet(16'hFFFF, POSE_TYPE, 32'hFFFF_FFFF);
        pkt.pos_x_bits = '1;
        pkt.pos_y_bits = '1;
        pkt.pos_z_bits = '1;
        pkt.pitch_bits = '1;
        pkt.yaw_bits   = '1;
        pkt.roll_bits  = '1;
        packet_queue.push_back(pkt);
        pkt = make_packet(MIN_LENGTH, POSE_TYPE, 32'd0);
        pkt.pos_x_bits = '0;
        pkt.pos_y_bits = '0;
        pkt.pos_z_bits = '0;
        pkt.pitch_bits = '0;
        pkt.yaw_bits   = '0;
        pkt.roll_bits  = '0;
        packet_queue.push_back(pkt);
        packet_queue.push_back(make_packet(16'd200, 8'h00, 32'd5));
        packet_queue.push_back(make_packet(16'd200, 8'hFF, 32'd5));
        wait_idle();

        // Interval dropped to the packet count so far: next accepted packet sweeps
        write_reg(REG_PRUNE_INTERVAL, 16'd3);
        write_reg(REG_PRUNE_AGE, 16'd2);
        packet_queue.push_back(make_packet(MIN_LENGTH, POSE_TYPE, 32'd0));
        packet_queue.push_back(make_packet(MIN_LENGTH, POSE_TYPE, 32'd1));
        packet_queue.push_back(make_packet(MIN_LENGTH, POSE_TYPE, 32'hFFFF_FFFF));
        packet_queue.push_back(make_packet(MIN_LENGTH, POSE_TYPE, 32'd2));
        packet_queue.push_back(make_packet(MIN_LENGTH, POSE_TYPE, 32'd1));
        packet_queue.push_back(make_packet(MIN_LENGTH, POSE_TYPE, 32'd3));
        wait_idle();

        // Zero interval and zero age: sweep after every packet, clearing all
        write_reg(REG_PRUNE_INTERVAL, 16'd0);
        write_reg(REG_PRUNE_AGE, 16'd0);
        packet_queue.push_back(make_packet(MIN_LENGTH, POSE_TYPE, 32'd4));
        packet_queue.push_back(make_packet(MIN_LENGTH, POSE_TYPE, 32'd5));
        packet_queue.push_back(make_packet(MIN_LENGTH, POSE_TYPE, 32'd4));
        wait_idle();

        // Sweep every packet with an age nothing reaches
        write_reg(REG_PRUNE_INTERVAL, 16'd1);
        write_reg(REG_PRUNE_AGE, 16'hFFFF);
        packet_queue.push_back(make_packet(MIN_LENGTH, POSE_TYPE, 32'd6));
        packet_queue.push_back(make_packet(MIN_LENGTH, POSE_TYPE, 32'd7));
        wait_idle();

        // Random phases, one register setting each
        for (ph = 0; ph < PHASES; ph++) begin
            if (ph_pool[ph] == 0) begin
                ph_interval[ph] = $urandom_range(2, 40);
                ph_age[ph]      = $urandom_range(2, 120);
                ph_pool[ph]     = $urandom_range(50, 140);
            end
            write_reg(REG_PRUNE_INTERVAL, CFG_W'(ph_interval[ph]));
            write_reg(REG_PRUNE_AGE, CFG_W'(ph_age[ph]));
            key_base = $urandom;
            repeat (PACKETS_PER_PHASE) begin
                packet_queue.push_back(random_packet(key_base, ph_pool[ph]));
            end
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (expected_outcomes.size() != 0) begin
            $display("%0t: %0d results expected, 0 actual", $time, expected_outcomes.size());
            errors++;
        end

        $display("Sent %0d packets, %0d past the filter: %0d inserts, %0d dropped on a full table",
                 n_packets, n_accepted, n_inserted, n_dropped);
        $display("%0d sweeps removed %0d entries; %0d register writes, %0d long receiver holds",
                 n_sweeps, n_removed, n_writes, n_holds);
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #10_000_000;
        $display("%0t: run timed out", $time);
        $display("Mismatches found");
        $finish;
    end

endmodule
